### src/tsvft_pkg.sv
// Shared constants and character codes for the tab-separated field tokenizer.
package tsvft_pkg;

    localparam int MAX_COLUMNS      = 4096;
    localparam int COL_BITS         = 13;
    localparam int FIELD_COUNT_BITS = 24;

    localparam logic [COL_BITS-1:0]         COL_MAX   = COL_BITS'(MAX_COLUMNS);
    localparam logic [FIELD_COUNT_BITS-1:0] FIELD_MAX = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic KIND_CONTENT   = 1'b0;
    localparam logic KIND_FIELD_END = 1'b1;

endpackage

### src/tsv_field_tokenizer.sv
// Top level of the tab-separated field tokenizer with quote handling.
//
// The input channel takes one word, a byte of tab-separated text, per cycle.
// The output channel gives either one content byte of the current field or
// one end-of-field mark with the field index, row end flag and header state.
// Quoted sections may hold tabs and line feeds; a doubled quote inside
// quotes gives one literal quote. Bytes that give no result are dropped.
// An accepted word is held in the input register, then its result is
// loaded into the output register, which shows it as valid. One word per
// cycle is sustained while the receiver does not stall; the parser state
// is updated by a single level of logic between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register keeps its word while that word would give a result; a
// word that gives no result still passes, and input stall is raised only
// when the input register cannot move on.
// A synchronous active-low reset clears the quote state, the field state,
// the header column count to one and the field counter to zero, and empties
// both registers. A final field without a tab or line feed is never ended.
module tsv_field_tokenizer
    import tsvft_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [7:0]                  i_text_byte,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_result_kind,
    output logic [7:0]                  o_content_byte,
    output logic [FIELD_COUNT_BITS-1:0] o_field_index,
    output logic                        o_row_end,
    output logic [COL_BITS-1:0]         o_header_columns,
    output logic                        o_header_done
);

    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;

    logic                        r_in_quotes,      n_in_quotes;
    logic                        r_quote_pending,  n_quote_pending;
    logic                        r_field_started,  n_field_started;
    logic                        r_field_cut_off,  n_field_cut_off;
    logic                        r_first_row_done, n_first_row_done;
    logic [COL_BITS-1:0]         r_column_total,   n_column_total;
    logic [FIELD_COUNT_BITS-1:0] r_field_counter,  n_field_counter;

    logic                        r_out_valid;
    logic                        r_result_kind;
    logic [7:0]                  r_content_byte;
    logic [FIELD_COUNT_BITS-1:0] r_field_index;
    logic                        r_row_end;
    logic [COL_BITS-1:0]         r_header_columns;
    logic                        r_header_done;

    logic       emit;
    logic       emit_kind;
    logic [7:0] emit_byte;
    logic       emit_row_end;
    logic       out_free;
    logic       proc_fire;

    always_comb begin
        logic [7:0] b;
        logic       quotes_v;
        logic       cut_v;
        logic       done;
        b                = r_in_byte;
        quotes_v         = r_in_quotes;
        cut_v            = r_field_cut_off;
        done             = 1'b0;
        n_in_quotes      = r_in_quotes;
        n_quote_pending  = r_quote_pending;
        n_field_started  = r_field_started;
        n_field_cut_off  = r_field_cut_off;
        n_first_row_done = r_first_row_done;
        n_column_total   = r_column_total;
        n_field_counter  = r_field_counter;
        emit             = 1'b0;
        emit_kind        = KIND_CONTENT;
        emit_byte        = b;
        emit_row_end     = 1'b0;

        if (r_quote_pending) begin
            n_quote_pending = 1'b0;
            if (b == CH_QUOTE) begin
                done = 1'b1;
                if (!cut_v) begin
                    n_field_started = 1'b1;
                    emit            = 1'b1;
                end
            end else begin
                quotes_v    = 1'b0;
                n_in_quotes = 1'b0;
                if (r_field_started) begin
                    cut_v           = 1'b1;
                    n_field_cut_off = 1'b1;
                end
            end
        end

        if (!done) begin
            if (quotes_v) begin
                if (b == CH_QUOTE) begin
                    n_quote_pending = 1'b1;
                end else if (b == CH_NUL) begin
                    if (r_field_started) begin
                        n_field_cut_off = 1'b1;
                    end
                end else if (!r_field_started && (b == CH_CR || b == CH_LF)) begin
                    n_field_started = r_field_started;
                end else if (!cut_v) begin
                    n_field_started = 1'b1;
                    emit            = 1'b1;
                end
            end else begin
                if (b == CH_TAB || b == CH_LF) begin
                    if (b == CH_TAB && !r_first_row_done && r_column_total < COL_MAX) begin
                        n_column_total = r_column_total + 1'b1;
                    end
                    if (b == CH_LF) begin
                        n_first_row_done = 1'b1;
                    end
                    emit         = 1'b1;
                    emit_kind    = KIND_FIELD_END;
                    emit_byte    = CH_NUL;
                    emit_row_end = (b == CH_LF);
                    if (r_field_counter != FIELD_MAX) begin
                        n_field_counter = r_field_counter + 1'b1;
                    end
                    n_field_started = 1'b0;
                    n_field_cut_off = 1'b0;
                end else if (b == CH_QUOTE) begin
                    n_in_quotes = 1'b1;
                    if (r_field_started) begin
                        n_field_cut_off = 1'b1;
                    end
                end else if (b == CH_NUL || b == CH_CR) begin
                    if (r_field_started) begin
                        n_field_cut_off = 1'b1;
                    end
                end else if (!cut_v) begin
                    n_field_started = 1'b1;
                    emit            = 1'b1;
                end
            end
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_fire  = r_in_valid && (!emit || out_free);
    assign o_in_stall = r_in_valid && !proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes      <= 1'b0;
            r_quote_pending  <= 1'b0;
            r_field_started  <= 1'b0;
            r_field_cut_off  <= 1'b0;
            r_first_row_done <= 1'b0;
            r_column_total   <= COL_BITS'(1);
            r_field_counter  <= '0;
        end else if (proc_fire) begin
            r_in_quotes      <= n_in_quotes;
            r_quote_pending  <= n_quote_pending;
            r_field_started  <= n_field_started;
            r_field_cut_off  <= n_field_cut_off;
            r_first_row_done <= n_first_row_done;
            r_column_total   <= n_column_total;
            r_field_counter  <= n_field_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc_fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emit) begin
            r_result_kind    <= emit_kind;
            r_content_byte   <= emit_byte;
            r_field_index    <= r_field_counter;
            r_row_end        <= emit_row_end;
            r_header_columns <= n_column_total;
            r_header_done    <= n_first_row_done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_result_kind;
    assign o_content_byte   = r_content_byte;
    assign o_field_index    = r_field_index;
    assign o_row_end        = r_row_end;
    assign o_header_columns = r_header_columns;
    assign o_header_done    = r_header_done;

endmodule

### src/tsvft_chk.sv
// Port-level checker for the tab-separated field tokenizer and its bind.
module tsvft_chk
    import tsvft_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_result_kind,
    input logic [7:0]                  o_content_byte,
    input logic [FIELD_COUNT_BITS-1:0] o_field_index,
    input logic                        o_row_end,
    input logic [COL_BITS-1:0]         o_header_columns,
    input logic                        o_header_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_content_byte)
            && $stable(o_result_kind) && $stable(o_field_index)))
        else $error("Stalled output word changed.");

    a_content_no_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_CONTENT) |-> !o_row_end)
        else $error("Content word flagged as row end.");

    a_header_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_header_done) |=> (!o_out_valid || o_header_done))
        else $error("Header done cleared after first row.");

    a_header_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_header_done) |=>
            (!o_out_valid || o_header_columns == $past(o_header_columns)))
        else $error("Header column count changed after first row.");

endmodule

bind tsv_field_tokenizer tsvft_chk u_tsvft_chk (.*);
